// File: rtl/artl_pkg.sv
package artl_pkg;

    localparam int ADDR_W  = 48;
    localparam int END_W   = 49;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] span_len;
        logic              is_writable;
        logic              is_image;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic               span_ok;
        logic [ADDR_W-1:0]  hit_start;
        logic [END_W-1:0]   hit_end;
        logic               hit_writable;
        logic               hit_image;
        logic               merged;
        logic               table_full;
        logic [COUNT_W-1:0] region_count;
    } out_item_t;

    // command after front-end classification
    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] span_len;
        logic [END_W-1:0]  span_end;
        logic              is_writable;
        logic              is_image;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE_RD,
        ST_SEARCH,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_HIT_RD,
        ST_DONE
    } state_t;

endpackage

// File: rtl/artl_front.sv
module artl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  artl_pkg::in_item_t  in_item,
    output logic                q_valid,
    input  logic                q_pop,
    output artl_pkg::work_t     q_item
);
    import artl_pkg::*;

    // two-entry queue between front and back
    work_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    work_t      w;
    logic       push;

    always_comb
    begin
        w.cmd         = cmd_t'(in_item.cmd);
        w.addr        = in_item.addr;
        w.span_len    = in_item.span_len;
        w.span_end    = {1'b0, in_item.addr} + {1'b0, in_item.span_len};
        w.is_writable = in_item.is_writable;
        w.is_image    = in_item.is_image;
    end

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 2'd2)
        else $error("queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd2 && !q_pop) |=> (fill_reg == 2'd2))
        else $error("queue lost an item");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0) |-> !q_pop || !q_valid)
        else $error("pop from empty queue");

endmodule

// File: rtl/artl_back.sv
module artl_back #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  artl_pkg::work_t     q_item,
    output logic                out_valid,
    input  logic                out_stall,
    output artl_pkg::out_item_t out_item
);
    import artl_pkg::*;

    localparam int ADDR_BITS = ADDR_W;
    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int EW = ADDR_BITS + 1;

    // one memory word: start, end, writable, image
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [EW-1:0]        fin;
        logic                 wr;
        logic                 im;
    } entry_t;

    entry_t mem [MAX_REGIONS];
    entry_t rd_data_reg;

    state_t        state_reg, state_next;
    work_t         job_reg, job_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] last_reg, last_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          wait_reg, wait_next;
    out_item_t     acc_reg, acc_next;
    out_item_t     res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic          mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    entry_t        mem_wd;
    logic [CW-1:0] mid;
    logic [EW-1:0] a_ext, q_end;

    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign a_ext = {1'b0, job_reg.addr[ADDR_BITS-1:0]};
    assign q_end = {1'b0, job_reg.addr[ADDR_BITS-1:0]}
                 + {1'b0, job_reg.span_len[ADDR_BITS-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ptr_next       = ptr_reg;
        wait_next      = 1'b0;
        acc_next       = acc_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && out_stall;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_ra         = '0;
        mem_wd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    job_next = q_item;
                    acc_next = '0;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    case (q_item.cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            last_next  = '0;
                            state_next = ST_DONE;
                        end
                        CMD_ADD:
                        begin
                            mem_ra     = last_reg;
                            state_next = ST_MERGE_RD;
                        end
                        CMD_QUERY:
                        begin
                            state_next = ST_SEARCH;
                            wait_next  = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MERGE_RD:
            begin
                if (count_reg != '0 && CW'(last_reg) < count_reg
                    && rd_data_reg.fin == a_ext
                    && rd_data_reg.wr == job_reg.is_writable
                    && rd_data_reg.im == job_reg.is_image)
                begin
                    mem_we          = 1'b1;
                    mem_wa          = last_reg;
                    mem_wd          = rd_data_reg;
                    mem_wd.fin      = job_reg.span_end[EW-1:0];
                    acc_next.merged = 1'b1;
                    state_next      = ST_DONE;
                end
                else if (count_reg == CW'(MAX_REGIONS))
                begin
                    acc_next.table_full = 1'b1;
                    state_next          = ST_DONE;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // binary search: issue read, then compare on next cycle
                if (!wait_reg)
                begin
                    if (lo_reg >= hi_reg)
                    begin
                        if (job_reg.cmd == CMD_ADD)
                        begin
                            ptr_next   = count_reg;
                            state_next = (count_reg == lo_reg) ? ST_SHIFT_WR
                                                               : ST_SHIFT_RD;
                        end
                        else if (lo_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            mem_ra     = IW'(lo_reg - 1'b1);
                            state_next = ST_HIT_RD;
                        end
                    end
                    else
                    begin
                        mem_ra    = mid[IW-1:0];
                        wait_next = 1'b1;
                    end
                end
                else
                begin
                    if (job_reg.addr[ADDR_BITS-1:0] < rd_data_reg.start)
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid + 1'b1;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                mem_ra     = IW'(ptr_reg - 1'b1);
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                mem_we = 1'b1;
                mem_wa = ptr_reg[IW-1:0];
                if (ptr_reg == lo_reg)
                begin
                    mem_wd.start = job_reg.addr[ADDR_BITS-1:0];
                    mem_wd.fin   = job_reg.span_end[EW-1:0];
                    mem_wd.wr    = job_reg.is_writable;
                    mem_wd.im    = job_reg.is_image;
                    count_next   = count_reg + 1'b1;
                    last_next    = lo_reg[IW-1:0];
                    state_next   = ST_DONE;
                end
                else
                begin
                    mem_wd   = rd_data_reg;
                    ptr_next = ptr_reg - 1'b1;
                    state_next = (ptr_reg - 1'b1 == lo_reg) ? ST_SHIFT_WR
                                                            : ST_SHIFT_RD;
                end
            end
            ST_HIT_RD:
            begin
                if (a_ext < rd_data_reg.fin)
                begin
                    acc_next.hit          = 1'b1;
                    acc_next.span_ok      = job_reg.addr != '0
                                          && job_reg.span_len != '0
                                          && q_end <= rd_data_reg.fin;
                    acc_next.hit_start    = ADDR_W'(rd_data_reg.start);
                    acc_next.hit_end      = END_W'(rd_data_reg.fin);
                    acc_next.hit_writable = rd_data_reg.wr;
                    acc_next.hit_image    = rd_data_reg.im;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !out_stall)
                begin
                    res_next              = acc_reg;
                    res_next.region_count = COUNT_W'(count_reg);
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            wait_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            wait_reg      <= wait_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        ptr_reg <= ptr_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_REGIONS))
        else $error("region count beyond table size");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> lo_reg <= hi_reg)
        else $error("search bounds crossed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> CW'(last_reg) < count_reg)
        else $error("last added slot outside table");

endmodule

// File: rtl/address_region_table_lookup_unit.sv
// Region table with clear, add and query commands, one result per item.
// Clear and unused commands go straight to the result. An add first reads the
// last added entry and merges into it, or is dropped if the table is full;
// else it binary-searches for its slot and shifts the entries from there up.
// A query binary-searches and then reads the entry below the slot found,
// unless no region starts at or below the address. Each search takes up to
// log2(MAX_REGIONS) + 1 probes. All of it goes through the one read port and
// one write port of the region memory; the back takes the next item once a
// result is registered. A two-item queue decouples input; a stalled result
// holds the back, after which the queue fills and in_stall rises.
module address_region_table_lookup_unit #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  artl_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output artl_pkg::out_item_t out_item
);
    import artl_pkg::*;

    logic  q_valid, q_pop;
    work_t q_item;

    artl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    artl_back #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import artl_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int IDLE_LIMIT  = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    address_region_table_lookup_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // predictor copy of the region table
    logic [ADDR_W-1:0] rgn_start [TABLE_DEPTH];
    logic [END_W-1:0]  rgn_end [TABLE_DEPTH];
    logic              rgn_wr [TABLE_DEPTH];
    logic              rgn_img [TABLE_DEPTH];
    int                rgn_count;
    int                last_slot;

    out_item_t pending_results[$];
    int        errors;
    int        idle_cycles;
    bit        hold_off;
    bit        stim_done;

    function automatic int slots_at_or_below(logic [ADDR_W-1:0] a);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = rgn_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (a < rgn_start[mid])
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic out_item_t apply_command(in_item_t it);
        out_item_t r;
        logic [END_W-1:0] span_end;
        int pos;
        r = '0;
        span_end = {1'b0, it.addr} + {1'b0, it.span_len};
        case (cmd_t'(it.cmd))
            CMD_CLEAR:
            begin
                rgn_count = 0;
                last_slot = 0;
            end
            CMD_ADD:
            begin
                if (rgn_count > 0 && last_slot < rgn_count
                    && rgn_end[last_slot] == {1'b0, it.addr}
                    && rgn_wr[last_slot] == it.is_writable
                    && rgn_img[last_slot] == it.is_image)
                begin
                    rgn_end[last_slot] = span_end;
                    r.merged = 1'b1;
                end
                else if (rgn_count >= TABLE_DEPTH)
                    r.table_full = 1'b1;
                else
                begin
                    pos = slots_at_or_below(it.addr);
                    for (int i = rgn_count; i > pos; i--)
                    begin
                        rgn_start[i] = rgn_start[i-1];
                        rgn_end[i]   = rgn_end[i-1];
                        rgn_wr[i]    = rgn_wr[i-1];
                        rgn_img[i]   = rgn_img[i-1];
                    end
                    rgn_start[pos] = it.addr;
                    rgn_end[pos]   = span_end;
                    rgn_wr[pos]    = it.is_writable;
                    rgn_img[pos]   = it.is_image;
                    rgn_count++;
                    last_slot = pos;
                end
            end
            CMD_QUERY:
            begin
                pos = slots_at_or_below(it.addr);
                if (pos > 0 && {1'b0, it.addr} < rgn_end[pos-1])
                begin
                    r.hit = 1'b1;
                    r.span_ok = it.addr != 0 && it.span_len != 0
                        && span_end <= rgn_end[pos-1];
                    r.hit_start    = rgn_start[pos-1];
                    r.hit_end      = rgn_end[pos-1];
                    r.hit_writable = rgn_wr[pos-1];
                    r.hit_image    = rgn_img[pos-1];
                end
            end
            default: ;
        endcase
        r.region_count = COUNT_W'(rgn_count);
        return r;
    endfunction

    // one input item; waits for acceptance
    task automatic offer(in_item_t it);
        out_item_t r;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = apply_command(it);
        pending_results = {pending_results, r};
        @(negedge clk);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(negedge clk);
    endtask

    function automatic in_item_t mk(cmd_t c, logic [ADDR_W-1:0] a,
                                    logic [ADDR_W-1:0] l, logic w, logic m);
        in_item_t it;
        it.cmd = c;
        it.addr = a;
        it.span_len = l;
        it.is_writable = w;
        it.is_image = m;
        return it;
    endfunction

    // random item aimed at a small address window so queries hit and adds merge
    function automatic in_item_t random_item();
        in_item_t it;
        int sel;
        logic [ADDR_W-1:0] base;
        sel = $urandom_range(0, 99);
        base = ADDR_W'({$urandom, $urandom});
        it.is_writable = 1'($urandom_range(0, 1));
        it.is_image = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0)
            base = base & 48'hFFFF;
        it.addr = base;
        it.span_len = ADDR_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 15) == 0)
            it.span_len = ADDR_W'({$urandom, $urandom});
        if (sel < 2)
            it.cmd = CMD_CLEAR;
        else if (sel < 4)
            it.cmd = CMD_NONE;
        else if (sel < 50)
        begin
            it.cmd = CMD_ADD;
            if (rgn_count > 0 && $urandom_range(0, 2) == 0)
            begin
                it.addr = rgn_end[last_slot][ADDR_W-1:0];
                it.is_writable = rgn_wr[last_slot];
                it.is_image = rgn_img[last_slot];
            end
        end
        else
        begin
            it.cmd = CMD_QUERY;
            if (rgn_count > 0 && $urandom_range(0, 3) != 0)
            begin
                sel = $urandom_range(0, rgn_count - 1);
                it.addr = rgn_start[sel] + ADDR_W'($urandom_range(0, 4095));
            end
        end
        return it;
    endfunction

    in_item_t directed_rows[$];
    out_item_t directed_expect[$];
    bit directed_known[$];

    task automatic row(in_item_t it, bit known, out_item_t r);
        directed_rows = {directed_rows, it};
        directed_known = {directed_known, known};
        directed_expect = {directed_expect, r};
    endtask

    function automatic out_item_t count_only(int n);
        out_item_t r;
        r = '0;
        r.region_count = COUNT_W'(n);
        return r;
    endfunction

    initial
    begin
        out_item_t r;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        errors = 0;
        stim_done = 1'b0;
        hold_off = 1'b0;
        rgn_count = 0;
        last_slot = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        row(mk(CMD_QUERY, '0, '0, 0, 0), 1, count_only(0));
        row(mk(CMD_NONE, '1, '1, 1, 1), 1, count_only(0));
        row(mk(CMD_ADD, 48'h1000, 48'h100, 1, 0), 1, count_only(1));
        r = count_only(1);
        r.merged = 1'b1;
        row(mk(CMD_ADD, 48'h1100, 48'h100, 1, 0), 1, r);
        row(mk(CMD_ADD, 48'h1200, 48'h10, 0, 1), 1, count_only(2));
        row(mk(CMD_ADD, 48'h1000, 48'h20, 0, 0), 0, '0);
        row(mk(CMD_ADD, 48'h0, 48'h0, 1, 1), 0, '0);
        row(mk(CMD_QUERY, 48'h1050, 48'h10, 0, 0), 0, '0);
        row(mk(CMD_QUERY, 48'h11FF, 48'h2, 0, 0), 0, '0);
        row(mk(CMD_QUERY, 48'h0, 48'h1, 0, 0), 0, '0);
        row(mk(CMD_QUERY, 48'h1210, 48'h1, 0, 0), 0, '0);
        row(mk(CMD_ADD, '1, '1, 1, 1), 0, '0);
        row(mk(CMD_QUERY, '1, '1, 0, 0), 0, '0);
        row(mk(CMD_QUERY, '1, 48'h0, 0, 0), 0, '0);
        row(mk(CMD_CLEAR, '1, '1, 1, 1), 1, count_only(0));
        foreach (directed_rows[i])
        begin
            offer(directed_rows[i]);
            if (directed_known[i] && pending_results[$] != directed_expect[i])
            begin
                $error("table row %0d: expected %h, model gives %h", i,
                    directed_expect[i], pending_results[$]);
                errors++;
            end
        end

        // fill past capacity: full table drops, mergeable add still merges
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            offer(mk(CMD_ADD, ADDR_W'(i * 64), 48'h10, i[0], 0));
        offer(mk(CMD_ADD, rgn_end[last_slot][ADDR_W-1:0], 48'h8,
                 rgn_wr[last_slot], 0));
        offer(mk(CMD_QUERY, 48'h44, 48'h4, 0, 0));
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
        offer(mk(CMD_CLEAR, '0, '0, 0, 0));

        // receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            offer(random_item());
        hold_off = 1'b0;

        n = 0;
        while (n < 850)
        begin
            repeat ($urandom_range(1, 20))
            begin
                offer(random_item());
                n++;
            end
            if ($urandom_range(0, 3) == 0)
                pause_sender();
            if (n % 300 < 15 && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge clk);
            end
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // stall pattern: runs of open and stalled cycles, forced high when hold-off starts, then released
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                out_stall <= 1'b0;
                wait (!hold_off);
            end
            else if ($urandom_range(0, 7) == 0)
                out_stall <= ~out_stall;
            else if (out_stall && $urandom_range(0, 2) == 0)
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing outstanding: %h", out_item);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.hit !== want.hit)
                begin
                    $error("hit: expected %0h, got %0h", want.hit, out_item.hit);
                    errors++;
                end
                if (out_item.span_ok !== want.span_ok)
                begin
                    $error("span_ok: expected %0h, got %0h", want.span_ok, out_item.span_ok);
                    errors++;
                end
                if (out_item.hit_start !== want.hit_start)
                begin
                    $error("hit_start: expected %0h, got %0h", want.hit_start,
                        out_item.hit_start);
                    errors++;
                end
                if (out_item.hit_end !== want.hit_end)
                begin
                    $error("hit_end: expected %0h, got %0h", want.hit_end, out_item.hit_end);
                    errors++;
                end
                if (out_item.hit_writable !== want.hit_writable)
                begin
                    $error("hit_writable: expected %0h, got %0h", want.hit_writable,
                        out_item.hit_writable);
                    errors++;
                end
                if (out_item.hit_image !== want.hit_image)
                begin
                    $error("hit_image: expected %0h, got %0h", want.hit_image,
                        out_item.hit_image);
                    errors++;
                end
                if (out_item.merged !== want.merged)
                begin
                    $error("merged: expected %0h, got %0h", want.merged, out_item.merged);
                    errors++;
                end
                if (out_item.table_full !== want.table_full)
                begin
                    $error("table_full: expected %0h, got %0h", want.table_full,
                        out_item.table_full);
                    errors++;
                end
                if (out_item.region_count !== want.region_count)
                begin
                    $error("region_count: expected %0d, got %0d", want.region_count,
                        out_item.region_count);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
        wait (stim_done);
        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: filelist.f
rtl/artl_pkg.sv
rtl/artl_front.sv
rtl/artl_back.sv
rtl/address_region_table_lookup_unit.sv
dv/tb.sv
